// ===== hdl/jrd_pkg.sv =====
// Package for the journal record deframer: word types, role and status codes,
// and configuration register indexes. No dependencies.
package jrd_pkg;

  typedef struct packed {
    logic       kind;
    logic [7:0] log_byte;
  } in_word_t;

  typedef struct packed {
    logic [2:0]  byte_role;
    logic [7:0]  byte_out;
    logic [7:0]  current_op;
    logic [31:0] key_length;
    logic [31:0] value_length;
    logic        record_done;
    logic [1:0]  tail_status;
    logic [31:0] keep_length;
  } out_word_t;

  typedef struct packed {
    logic [7:0] put_code;
    logic [7:0] delete_code;
    logic [7:0] clear_code;
  } op_codes_t;

  localparam logic KIND_DATA = 1'b0;
  localparam logic KIND_END  = 1'b1;

  localparam logic [2:0] ROLE_OP      = 3'd0;
  localparam logic [2:0] ROLE_KEY_LEN = 3'd1;
  localparam logic [2:0] ROLE_KEY     = 3'd2;
  localparam logic [2:0] ROLE_VAL_LEN = 3'd3;
  localparam logic [2:0] ROLE_VAL     = 3'd4;
  localparam logic [2:0] ROLE_DISCARD = 3'd5;

  localparam logic [1:0] TAIL_CLEAN     = 2'd0;
  localparam logic [1:0] TAIL_TRUNCATED = 2'd1;
  localparam logic [1:0] TAIL_BAD_OP    = 2'd2;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_PUT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DELETE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CLEAR  = 2'd2;

  localparam logic [7:0] OP_RESET_PUT    = 8'd0;
  localparam logic [7:0] OP_RESET_DELETE = 8'd1;
  localparam logic [7:0] OP_RESET_CLEAR  = 8'd2;

endpackage

// ===== hdl/journal_record_deframer_core.sv =====
// Top level of the journal record deframer: input stage, result register,
// op code registers and handshake. Depends on jrd_pkg and jrd_parser.
//
// Usage:
//   in_valid/in_stall/in_data carry one word per log byte (kind = 0) or an
//   end-of-log marker (kind = 1). Each word produces exactly one result word
//   on out_valid/out_stall/out_data: the byte role, the byte, the current op
//   and lengths, a record-done flag and the keep length for data bytes; the
//   tail status and keep length for an end marker. An end marker restarts the parser.
//   cfg_valid/cfg_ready/cfg_index/cfg_data write the put, delete and clear
//   op codes (indexes 0, 1, 2). cfg_ready is always high; write only while
//   no words are in flight.
// Timing:
//   The input register takes a word at its accept edge; the parser result
//   is loaded into the result register when the input stage fires, which
//   out_stall can hold off; out_valid comes straight from that register.
//   Throughput is one word per cycle unless out_stall holds a full result.
// Reset:
//   rst_n (synchronous) empties both stages, restores op codes 0/1/2 and
//   returns the parser to expecting an op byte with zero offsets.
// Backpressure:
//   While out_stall holds a full result register, the input stage holds its
//   word and in_stall rises only if that stage is occupied.
module journal_record_deframer_core import jrd_pkg::*; #(
  parameter int LENGTH_BITS = 32,
  parameter int OFFSET_BITS = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_word_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_word_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]           cfg_data
);

  logic      s1_valid_r, s1_valid_nxt;
  in_word_t  s1_word_r;
  logic      out_valid_r, out_valid_nxt;
  out_word_t out_word_r;
  op_codes_t codes_r;
  out_word_t result;
  logic      out_adv;
  logic      s1_fire;
  logic      in_fire;

  // Advance the result register when it is empty or being taken.
  assign out_adv   = !out_valid_r || !out_stall;
  assign s1_fire   = s1_valid_r && out_adv;
  assign in_stall  = s1_valid_r && !out_adv;
  assign in_fire   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;
  assign cfg_ready = 1'b1;

  assign s1_valid_nxt  = in_fire || (s1_valid_r && !s1_fire);
  assign out_valid_nxt = s1_fire || (out_valid_r && out_stall);

  jrd_parser #(
    .LENGTH_BITS(LENGTH_BITS),
    .OFFSET_BITS(OFFSET_BITS)
  ) u_parser (
    .clk    (clk),
    .rst_n  (rst_n),
    .go     (s1_fire),
    .word   (s1_word_r),
    .codes  (codes_r),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers: load on advance, hold otherwise.
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_word_r <= in_data;
    end
    if (s1_fire) begin
      out_word_r <= result;
    end
  end

  // Op code registers; an index beyond the list is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      codes_r.put_code    <= OP_RESET_PUT;
      codes_r.delete_code <= OP_RESET_DELETE;
      codes_r.clear_code  <= OP_RESET_CLEAR;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_PUT:    codes_r.put_code    <= cfg_data;
        CFG_DELETE: codes_r.delete_code <= cfg_data;
        CFG_CLEAR:  codes_r.clear_code  <= cfg_data;
        default:    ;
      endcase
    end
  end

  // An empty input stage never pushes back.
  a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_valid_r |-> !in_stall)
    else $error("in_stall raised with empty input stage");

  // A word leaving the input stage lands in the result register.
  a_fire_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire |=> out_valid_r)
    else $error("parsed word lost between stages");

  // A record can only end on a value byte or the last value length byte.
  a_done_role: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.record_done) |->
      (out_word_r.byte_role == ROLE_VAL || out_word_r.byte_role == ROLE_VAL_LEN))
    else $error("record_done on unexpected byte role");

endmodule

// ===== hdl/jrd_parser.sv =====
// Record parser state machine: per-word phase tracking, length assembly,
// byte countdown and saturating offsets. Depends on jrd_pkg.
module jrd_parser import jrd_pkg::*; #(
  parameter int LENGTH_BITS = 32,
  parameter int OFFSET_BITS = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      go,
  input  in_word_t  word,
  input  op_codes_t codes,
  output out_word_t result
);

  typedef enum logic [2:0] {
    PH_OP, PH_KLEN, PH_KEY, PH_VLEN, PH_VAL, PH_DISCARD
  } phase_t;

  localparam logic [32:0] LEN_MAX = (33'd1 << LENGTH_BITS) - 33'd1;

  phase_t                 phase_r, phase_nxt;
  logic [1:0]             idx_r, idx_nxt;
  logic [23:0]            acc_r, acc_nxt;
  logic [LENGTH_BITS-1:0] rem_r, rem_nxt;
  logic [7:0]             op_r, op_nxt;
  logic [LENGTH_BITS-1:0] klen_r, klen_nxt;
  logic [LENGTH_BITS-1:0] vlen_r, vlen_nxt;
  logic [OFFSET_BITS-1:0] log_r, log_nxt;
  logic [OFFSET_BITS-1:0] kept_r, kept_nxt;
  logic                   bad_r, bad_nxt;

  logic [7:0]             b;
  logic [31:0]            full_len;
  logic [LENGTH_BITS-1:0] len;
  logic [LENGTH_BITS-1:0] rem_dec;
  logic                   op_ok;
  logic                   done;
  logic [2:0]             role;
  logic [63:0]            kept_ext;

  assign b        = word.log_byte;
  assign full_len = {b, acc_r};
  assign len      = ({1'b0, full_len} > LEN_MAX) ? LEN_MAX[LENGTH_BITS-1:0]
                                                 : full_len[LENGTH_BITS-1:0];
  assign rem_dec  = rem_r - LENGTH_BITS'(1);
  assign op_ok    = (b == codes.put_code) || (b == codes.delete_code) ||
                    (b == codes.clear_code);

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    acc_nxt   = acc_r;
    rem_nxt   = rem_r;
    op_nxt    = op_r;
    klen_nxt  = klen_r;
    vlen_nxt  = vlen_r;
    bad_nxt   = bad_r;
    done      = 1'b0;
    role      = ROLE_DISCARD;
    log_nxt   = (log_r != '1) ? log_r + OFFSET_BITS'(1) : log_r;

    // Place a length byte little-endian; the fourth byte closes the length.
    if (phase_r == PH_KLEN || phase_r == PH_VLEN) begin
      case (idx_r)
        2'd0:    acc_nxt[7:0]   = b;
        2'd1:    acc_nxt[15:8]  = b;
        2'd2:    acc_nxt[23:16] = b;
        default: acc_nxt        = '0;
      endcase
      idx_nxt = idx_r + 2'd1;
    end

    unique case (phase_r)
      PH_OP: begin
        role     = ROLE_OP;
        op_nxt   = b;
        klen_nxt = '0;
        vlen_nxt = '0;
        idx_nxt  = '0;
        acc_nxt  = '0;
        if (op_ok) begin
          phase_nxt = PH_KLEN;
        end else begin
          bad_nxt   = 1'b1;
          phase_nxt = PH_DISCARD;
        end
      end
      PH_KLEN: begin
        role = ROLE_KEY_LEN;
        if (idx_r == 2'd3) begin
          klen_nxt  = len;
          rem_nxt   = len;
          phase_nxt = (len != '0) ? PH_KEY : PH_VLEN;
        end
      end
      PH_KEY: begin
        role    = ROLE_KEY;
        rem_nxt = rem_dec;
        if (rem_dec == '0) begin
          phase_nxt = PH_VLEN;
        end
      end
      PH_VLEN: begin
        role = ROLE_VAL_LEN;
        if (idx_r == 2'd3) begin
          vlen_nxt = len;
          rem_nxt  = len;
          if (len != '0) begin
            phase_nxt = PH_VAL;
          end else begin
            done      = 1'b1;
            phase_nxt = PH_OP;
          end
        end
      end
      PH_VAL: begin
        role    = ROLE_VAL;
        rem_nxt = rem_dec;
        if (rem_dec == '0) begin
          done      = 1'b1;
          phase_nxt = PH_OP;
        end
      end
      default: begin
        role      = ROLE_DISCARD;
        phase_nxt = PH_DISCARD;
      end
    endcase

    kept_nxt = done ? log_nxt : kept_r;
    kept_ext = 64'(kept_nxt);
    if (word.kind == KIND_END) begin
      kept_ext = 64'(kept_r);
    end

    result              = '0;
    result.keep_length  = (kept_ext > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF
                                                                : kept_ext[31:0];
    if (word.kind == KIND_END) begin
      result.tail_status = bad_r ? TAIL_BAD_OP :
                           ((phase_r != PH_OP) ? TAIL_TRUNCATED : TAIL_CLEAN);
    end else begin
      result.byte_role    = role;
      result.byte_out     = b;
      result.current_op   = op_nxt;
      result.key_length   = 32'(klen_nxt);
      result.value_length = 32'(vlen_nxt);
      result.record_done  = done;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (go && word.kind == KIND_END)) begin
      phase_r <= PH_OP;
      idx_r   <= '0;
      acc_r   <= '0;
      rem_r   <= '0;
      op_r    <= '0;
      klen_r  <= '0;
      vlen_r  <= '0;
      log_r   <= '0;
      kept_r  <= '0;
      bad_r   <= 1'b0;
    end else if (go) begin
      phase_r <= phase_nxt;
      idx_r   <= idx_nxt;
      acc_r   <= acc_nxt;
      rem_r   <= rem_nxt;
      op_r    <= op_nxt;
      klen_r  <= klen_nxt;
      vlen_r  <= vlen_nxt;
      log_r   <= log_nxt;
      kept_r  <= kept_nxt;
      bad_r   <= bad_nxt;
    end
  end

endmodule

// ===== tb/journal_record_deframer_core_tb.sv =====
`timescale 1ns / 1ps
// Testbench for journal_record_deframer_core: random and directed journal logs,
// a word-level predictor of the deframer and a scoreboard. Depends on jrd_pkg.
module journal_record_deframer_core_tb;
  import jrd_pkg::*;

  localparam int HOLD_CYCLES = 150;
  localparam int DRAIN_LIMIT = 100000;

  typedef enum logic [2:0] {
    ST_OP, ST_KEY_LEN, ST_KEY, ST_VAL_LEN, ST_VAL, ST_DISCARD
  } parse_state_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_word_t             in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_word_t            out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [7:0]           cfg_data = '0;

  // Stimulus and scoreboard storage.
  in_word_t   log_words[$];          // words waiting for the driver
  out_word_t  predicted_results[$];  // results owed by the block, oldest first
  logic [7:0] record_bytes[$];       // scratch for building one record
  int         words_queued = 0;
  int         mismatch_count = 0;
  logic       in_taken = 1'b0;       // input word accepted at the last rising edge
  int         send_idle_pct = 0;
  int         stall_pct = 0;
  logic       hold_req = 1'b0;
  logic       long_hold = 1'b0;
  out_word_t  want;

  // Predictor state: op codes as the block holds them, and the parser.
  op_codes_t    codes;
  parse_state_t ps;
  logic [1:0]   len_idx;
  logic [31:0]  len_acc;
  logic [31:0]  left_bytes;
  logic [7:0]   op_q;
  logic [31:0]  key_len_q;
  logic [31:0]  val_len_q;
  logic [31:0]  byte_count;
  logic [31:0]  kept_count;
  logic         bad_op_flag;

  journal_record_deframer_core u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Return the parser to the start of a fresh log; op codes are kept.
  function automatic void restart_parser();
    ps          = ST_OP;
    len_idx     = '0;
    len_acc     = '0;
    left_bytes  = '0;
    op_q        = '0;
    key_len_q   = '0;
    val_len_q   = '0;
    byte_count  = '0;
    kept_count  = '0;
    bad_op_flag = 1'b0;
  endfunction

  // Fold one little-endian length byte in; return 1 once all four are in.
  function automatic logic take_len_byte(input logic [7:0] b, output logic [31:0] len);
    len = '0;
    len_acc = len_acc | (32'(b) << (8 * len_idx));
    if (len_idx != 2'd3) begin
      len_idx = len_idx + 2'd1;
      return 1'b0;
    end
    len_idx = '0;
    len     = len_acc;
    len_acc = '0;
    return 1'b1;
  endfunction

  // Compute the result word for one accepted input word and advance the parser.
  function automatic out_word_t deframe_word(input in_word_t w);
    out_word_t   r;
    logic [31:0] len;
    logic        done;
    r    = '0;
    done = 1'b0;
    if (w.kind == KIND_END) begin
      if (bad_op_flag) r.tail_status = TAIL_BAD_OP;
      else if (ps != ST_OP) r.tail_status = TAIL_TRUNCATED;
      else r.tail_status = TAIL_CLEAN;
      r.keep_length = kept_count;
      restart_parser();
      return r;
    end
    // Saturate the running offset rather than wrap.
    if (byte_count != 32'hFFFF_FFFF) byte_count = byte_count + 32'd1;
    case (ps)
      ST_OP: begin
        r.byte_role = ROLE_OP;
        op_q      = w.log_byte;
        key_len_q = '0;
        val_len_q = '0;
        len_idx   = '0;
        len_acc   = '0;
        // Any register may match; duplicates are legal.
        if (w.log_byte == codes.put_code || w.log_byte == codes.delete_code ||
            w.log_byte == codes.clear_code) begin
          ps = ST_KEY_LEN;
        end else begin
          bad_op_flag = 1'b1;
          ps          = ST_DISCARD;
        end
      end
      ST_KEY_LEN: begin
        r.byte_role = ROLE_KEY_LEN;
        if (take_len_byte(w.log_byte, len)) begin
          key_len_q  = len;
          left_bytes = len;
          ps = (len != 0) ? ST_KEY : ST_VAL_LEN;
        end
      end
      ST_KEY: begin
        r.byte_role = ROLE_KEY;
        left_bytes = left_bytes - 32'd1;
        if (left_bytes == 0) ps = ST_VAL_LEN;
      end
      ST_VAL_LEN: begin
        r.byte_role = ROLE_VAL_LEN;
        if (take_len_byte(w.log_byte, len)) begin
          val_len_q  = len;
          left_bytes = len;
          if (len != 0) begin
            ps = ST_VAL;
          end else begin
            // Empty value: the last length byte closes the record.
            done = 1'b1;
            ps   = ST_OP;
          end
        end
      end
      ST_VAL: begin
        r.byte_role = ROLE_VAL;
        left_bytes = left_bytes - 32'd1;
        if (left_bytes == 0) begin
          done = 1'b1;
          ps   = ST_OP;
        end
      end
      default: begin
        r.byte_role = ROLE_DISCARD;
        ps = ST_DISCARD;
      end
    endcase
    if (done) kept_count = byte_count;
    r.byte_out     = w.log_byte;
    r.current_op   = op_q;
    r.key_length   = key_len_q;
    r.value_length = val_len_q;
    r.record_done  = done;
    r.keep_length  = kept_count;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor and scoreboard: sample everything at the rising edge.
  // ---------------------------------------------------------------------------

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      // Hold the predictor in its reset state along with the block.
      in_taken = 1'b0;
      codes.put_code    = OP_RESET_PUT;
      codes.delete_code = OP_RESET_DELETE;
      codes.clear_code  = OP_RESET_CLEAR;
      restart_parser();
    end else begin
      // Retire a result word against the oldest prediction.
      if (out_valid && !out_stall) begin
        if (predicted_results.size() == 0) begin
          $display("%0t: result word with no prediction waiting, actual %h",
                   $time, out_data);
          mismatch_count++;
        end else begin
          want = predicted_results.pop_front();
          check_field("byte_role",    want.byte_role,    out_data.byte_role);
          check_field("byte_out",     want.byte_out,     out_data.byte_out);
          check_field("current_op",   want.current_op,   out_data.current_op);
          check_field("key_length",   want.key_length,   out_data.key_length);
          check_field("value_length", want.value_length, out_data.value_length);
          check_field("record_done",  want.record_done,  out_data.record_done);
          check_field("tail_status",  want.tail_status,  out_data.tail_status);
          check_field("keep_length",  want.keep_length,  out_data.keep_length);
        end
      end
      // Track op code writes exactly when the block takes them.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PUT:    codes.put_code    = cfg_data;
          CFG_DELETE: codes.delete_code = cfg_data;
          CFG_CLEAR:  codes.clear_code  = cfg_data;
          default: ;
        endcase
      end
      // Predict the result of every accepted input word.
      in_taken = in_valid && !in_stall;
      if (in_taken) predicted_results = {predicted_results, deframe_word(in_data)};
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: change inputs on the falling edge only.
  // ---------------------------------------------------------------------------

  // Keep a stalled word on the bus; once taken, either offer the next word or
  // idle. The choice to offer never looks at in_stall.
  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      if (log_words.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data  <= log_words.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall, forced high during the long hold-off.
  always @(negedge clk) begin
    out_stall <= long_hold || ($urandom_range(0, 99) < stall_pct);
  end

  // Long hold-off, counted here so the sender keeps pushing into a full block.
  initial begin
    wait (hold_req);
    @(negedge clk);
    long_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(negedge clk);
    long_hold <= 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  task automatic push_word(input logic kind, input logic [7:0] b);
    in_word_t w;
    w.kind     = kind;
    w.log_byte = b;
    log_words = {log_words, w};
    words_queued++;
  endtask

  task automatic push_len(input logic [31:0] len);
    for (int i = 0; i < 4; i++) push_word(KIND_DATA, len[8*i +: 8]);
  endtask

  function automatic logic [7:0] valid_op();
    case ($urandom_range(0, 2))
      0:       return codes.put_code;
      1:       return codes.delete_code;
      default: return codes.clear_code;
    endcase
  endfunction

  function automatic logic [7:0] bad_op();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    while (b == codes.put_code || b == codes.delete_code || b == codes.clear_code)
      b = 8'($urandom_range(0, 255));
    return b;
  endfunction

  // Build one record into record_bytes. Stop early once a body is longer than
  // cap, since anything after it could never be reached.
  task automatic build_record(input logic [7:0] op, input logic [31:0] klen,
                              input logic [31:0] vlen, input int cap);
    record_bytes.delete();
    record_bytes = {record_bytes, op};
    for (int i = 0; i < 4; i++) record_bytes = {record_bytes, klen[8*i +: 8]};
    for (int i = 0; i < cap && i < klen; i++)
      record_bytes = {record_bytes, 8'($urandom_range(0, 255))};
    if (klen > cap) return;
    for (int i = 0; i < 4; i++) record_bytes = {record_bytes, vlen[8*i +: 8]};
    for (int i = 0; i < cap && i < vlen; i++)
      record_bytes = {record_bytes, 8'($urandom_range(0, 255))};
  endtask

  // One log: mostly complete records with random content, sometimes ending in
  // an unknown op, a cut-off record or raw noise. Always close with an end word.
  task automatic push_random_log();
    int n_rec;
    int pick;
    int cut;
    logic [31:0] klen;
    logic [31:0] vlen;
    n_rec = $urandom_range(0, 4);
    for (int r = 0; r < n_rec; r++) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        build_record(valid_op(), $urandom_range(0, 5), $urandom_range(0, 5), 8);
        foreach (record_bytes[i]) push_word(KIND_DATA, record_bytes[i]);
      end else if (pick < 88) begin
        push_word(KIND_DATA, bad_op());
        repeat ($urandom_range(0, 6)) push_word(KIND_DATA, 8'($urandom_range(0, 255)));
        break;
      end else if (pick < 96) begin
        // Full-range lengths only show up in records that get cut off.
        klen = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 5);
        vlen = $urandom_range(0, 1) ? $urandom() : $urandom_range(0, 5);
        build_record(valid_op(), klen, vlen, 5);
        cut = $urandom_range(1, record_bytes.size() - 1);
        for (int i = 0; i < cut; i++) push_word(KIND_DATA, record_bytes[i]);
        break;
      end else begin
        repeat ($urandom_range(1, 12)) push_word(KIND_DATA, 8'($urandom_range(0, 255)));
        break;
      end
    end
    push_word(KIND_END, 8'($urandom_range(0, 255)));
  endtask

  task automatic push_random_logs(input int n_words);
    int start;
    start = words_queued;
    while (words_queued - start < n_words) push_random_log();
  endtask

  // Wait until every word is sent and every result is back, then let the
  // two-stage pipeline settle.
  task automatic wait_idle();
    for (int n = 0; n < DRAIN_LIMIT; n++) begin
      if (log_words.size() == 0 && !in_valid && predicted_results.size() == 0) break;
      @(posedge clk);
    end
    repeat (6) @(posedge clk);
  endtask

  task automatic write_code(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_codes(input logic [7:0] put_v, input logic [7:0] del_v,
                           input logic [7:0] clr_v);
    write_code(CFG_PUT, put_v);
    write_code(CFG_DELETE, del_v);
    write_code(CFG_CLEAR, clr_v);
    @(posedge clk);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    @(posedge clk);
    send_idle_pct = send_pct;
    stall_pct     = recv_pct;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------

  initial begin
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Write the reset codes back explicitly so each register sees a write.
    set_codes(OP_RESET_PUT, OP_RESET_DELETE, OP_RESET_CLEAR);
    set_idling(0, 0);

    // Directed: empty log, then put with an empty key and a one-byte value.
    push_word(KIND_END, 8'h00);
    push_word(KIND_DATA, OP_RESET_PUT);
    push_len(32'd0);
    push_len(32'd1);
    push_word(KIND_DATA, 8'hFF);
    // Delete with empty key and empty value: closes on its last length byte.
    push_word(KIND_DATA, OP_RESET_DELETE);
    push_len(32'd0);
    push_len(32'd0);
    // Unknown op, a discarded byte, then the end word reports the bad op.
    push_word(KIND_DATA, 8'hFF);
    push_word(KIND_DATA, 8'h00);
    push_word(KIND_END, 8'hFF);
    // Clear op cut off right away: truncated tail.
    push_word(KIND_DATA, OP_RESET_CLEAR);
    push_word(KIND_END, 8'h00);
    wait_idle();

    // Phase with no idling on either side.
    push_random_logs(350);
    wait_idle();

    // All codes equal and at the top of the range; sender mostly idle.
    set_codes(8'hFF, 8'hFF, 8'hFF);
    set_idling(73, 0);
    push_random_logs(350);
    wait_idle();

    // All codes zero; receiver mostly stalling.
    set_codes(8'h00, 8'h00, 8'h00);
    set_idling(0, 73);
    push_random_logs(350);
    wait_idle();

    // Random codes; both sides idle now and then.
    set_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)));
    set_idling(29, 29);
    push_random_logs(350);
    wait_idle();

    // Back-pressure: sender streams while the receiver holds off for a long
    // stretch, filling the block and forcing in_stall.
    set_codes(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
              8'($urandom_range(0, 255)));
    set_idling(0, 0);
    push_random_logs(250);
    hold_req = 1'b1;
    wait_idle();

    if (predicted_results.size() != 0) begin
      $display("%0t: %0d predicted results never arrived", $time,
               predicted_results.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("journal_record_deframer_core_tb: done, clean");
    end else begin
      $display("journal_record_deframer_core_tb: done, errors");
    end
    $finish;
  end

  // Watchdog well beyond the slowest legal run.
  initial begin
    #2000000;
    $display("journal_record_deframer_core_tb: done, errors");
    $finish;
  end

endmodule

// ===== files.f =====
hdl/jrd_pkg.sv
hdl/jrd_parser.sv
hdl/journal_record_deframer_core.sv
tb/journal_record_deframer_core_tb.sv
